### sv/idt_pkg.sv
// Shared types and constants for the instruction dependency tracker.
// No dependencies; compiled first.
package idt_pkg;

    localparam int DEF_WINDOW    = 64;
    localparam int DEF_ARRAY_IDS = 256;
    localparam int ID_W          = 8;   // array id field width
    localparam int IDX_OUT_W     = 6;   // instr_index port width
    localparam int MASK_OUT_W    = 64;  // dep_mask port width
    localparam int CNT_OUT_W     = 7;   // dep_count port width
    localparam int EPOCH_W       = 8;   // batch tag stored with each entry
    localparam int ID_SPACE      = 1 << ID_W;

    typedef enum logic [1:0] {
        PORT_OUT = 2'd0,
        PORT_IN1 = 2'd1,
        PORT_IN2 = 2'd2
    } t_port;

    typedef struct packed {
        logic  capture;    // latch the input item
        logic  new_batch;  // restart index, advance epoch
        logic  sweep;      // clear one table entry
        logic  take_index; // assign index, clear dependency accumulator
        logic  overflow;   // mark current item as window overflow
        logic  rd_en;      // table read at selected operand
        logic  wr_en;      // table update at selected operand
        t_port port;
        logic  finish;     // load result register
    } t_cmd;

    typedef struct packed {
        logic       sweep_done;
        logic       need_sweep;
        logic       first;
        logic       full;
        logic       empty;
        logic       live1;
        logic       live2;
        logic       out_busy;
    } t_stat;

endpackage

### sv/idt_ctrl.sv
// Sequencer for the dependency tracker: table clear, per-operand
// read-modify-write and result handoff. Uses idt_pkg.
module idt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  idt_pkg::t_stat i_stat,
    output idt_pkg::t_cmd  o_cmd
);
    import idt_pkg::*;

    typedef enum logic [10:0] {
        S_SWEEP_RST  = 11'b00000000001,
        S_IDLE       = 11'b00000000010,
        S_START      = 11'b00000000100,
        S_SWEEP_ITEM = 11'b00000001000,
        S_CHECK      = 11'b00000010000,
        S_RD_OUT     = 11'b00000100000,
        S_WR_OUT     = 11'b00001000000,
        S_RD_IN1     = 11'b00010000000,
        S_WR_IN1     = 11'b00100000000,
        S_RD_IN2     = 11'b01000000000,
        S_WR_IN2     = 11'b10000000000
    } t_state;

    // FINISH shares no state: a dedicated flag keeps the result pending
    t_state r_state, n_state;
    logic   r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP_RST;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state = r_state;
        n_pend  = r_pend;
        o_cmd   = '0;
        o_cmd.port = PORT_OUT;
        o_ready = 1'b0;
        case (r_state)
            S_SWEEP_RST: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (r_pend) begin
                    if (!i_stat.out_busy) begin
                        o_cmd.finish = 1'b1;
                        n_pend = 1'b0;
                    end
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        o_cmd.capture = 1'b1;
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                if (i_stat.first) begin
                    o_cmd.new_batch = 1'b1;
                    n_state = i_stat.need_sweep ? S_SWEEP_ITEM : S_CHECK;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_SWEEP_ITEM: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.full) begin
                    o_cmd.overflow = 1'b1;
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.take_index = 1'b1;
                    if (i_stat.empty) begin
                        n_pend  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_RD_OUT;
                    end
                end
            end
            S_RD_OUT: begin
                o_cmd.rd_en = 1'b1;
                n_state = S_WR_OUT;
            end
            S_WR_OUT: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.live1) begin
                    n_state = S_RD_IN1;
                end else if (i_stat.live2) begin
                    n_state = S_RD_IN2;
                end else begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD_IN1: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.port  = PORT_IN1;
                n_state = S_WR_IN1;
            end
            S_WR_IN1: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.port  = PORT_IN1;
                if (i_stat.live2) begin
                    n_state = S_RD_IN2;
                end else begin
                    n_pend  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RD_IN2: begin
                o_cmd.rd_en = 1'b1;
                o_cmd.port  = PORT_IN2;
                n_state = S_WR_IN2;
            end
            S_WR_IN2: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.port  = PORT_IN2;
                n_pend  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_SWEEP_RST;
                n_pend  = 1'b0;
            end
        endcase
    end

    a_rd_then_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |=> o_cmd.wr_en && (o_cmd.port == $past(o_cmd.port)))
        else $error("table read not followed by write-back on same operand");

    a_sweep_no_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sweep |-> !o_cmd.rd_en && !o_cmd.wr_en)
        else $error("operand access during table clear");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid) |=> !o_ready)
        else $error("second item taken while one is in work");

endmodule

### sv/idt_dp.sv
// Datapath of the dependency tracker: array table memory, epoch tags,
// index counter, dependency accumulator and result register. Uses idt_pkg.
module idt_dp #(
    parameter int WINDOW    = idt_pkg::DEF_WINDOW,
    parameter int ARRAY_IDS = idt_pkg::DEF_ARRAY_IDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_first_in_batch,
    input  logic [1:0]                      i_operand_count,
    input  logic [idt_pkg::ID_W-1:0]        i_out_array,
    input  logic [idt_pkg::ID_W-1:0]        i_in1_array,
    input  logic                            i_in1_constant,
    input  logic [idt_pkg::ID_W-1:0]        i_in2_array,
    input  logic                            i_in2_constant,
    input  idt_pkg::t_cmd                   i_cmd,
    output idt_pkg::t_stat                  o_stat,
    input  logic                            i_ready,
    output logic                            o_valid,
    output logic [idt_pkg::IDX_OUT_W-1:0]   o_instr_index,
    output logic [idt_pkg::MASK_OUT_W-1:0]  o_dep_mask,
    output logic [idt_pkg::CNT_OUT_W-1:0]   o_dep_count,
    output logic                            o_window_overflow
);
    import idt_pkg::*;

    localparam int AW  = (ARRAY_IDS > 1) ? $clog2(ARRAY_IDS) : 1;
    localparam int IW  = $clog2(WINDOW);
    localparam int NW  = $clog2(WINDOW + 1);
    localparam int EW  = EPOCH_W + 1 + IW + WINDOW;

    typedef struct packed {
        logic [EPOCH_W-1:0] tag;
        logic               wv;
        logic [IW-1:0]      widx;
        logic [WINDOW-1:0]  rmask;
    } t_entry;

    // id folding table, constant per parameter set
    logic [AW-1:0] w_fold [ID_SPACE];
    for (genvar g = 0; g < ID_SPACE; g++) begin : g_fold
        assign w_fold[g] = AW'(g % ARRAY_IDS);
    end

    t_entry r_mem [ARRAY_IDS];
    t_entry r_rd;

    logic               r_first;
    logic [1:0]         r_nops;
    logic [ID_W-1:0]    r_out, r_in1, r_in2;
    logic               r_c1, r_c2;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_swp;
    logic [NW-1:0]      r_next;
    logic [IW-1:0]      r_idx;
    logic [WINDOW-1:0]  r_deps;
    logic               r_ovf;

    logic [AW-1:0]      w_a_out, w_a_in1, w_a_in2, w_addr;
    logic               w_cur;
    logic               w_eff_wv;
    logic [WINDOW-1:0]  w_eff_mask, w_wbit, w_self, w_dep_add;
    t_entry             w_wdata;
    logic               w_alias;
    logic [CNT_OUT_W-1:0] w_cnt;

    assign w_a_out = w_fold[r_out];
    assign w_a_in1 = w_fold[r_in1];
    assign w_a_in2 = w_fold[r_in2];

    always_comb begin
        case (i_cmd.port)
            PORT_OUT: w_addr = w_a_out;
            PORT_IN1: w_addr = w_a_in1;
            PORT_IN2: w_addr = w_a_in2;
            default:  w_addr = w_a_out;
        endcase
    end

    // entry from an older batch reads as cleared
    assign w_cur      = (r_rd.tag == r_epoch);
    assign w_eff_wv   = w_cur && r_rd.wv;
    assign w_eff_mask = w_cur ? r_rd.rmask : '0;
    assign w_wbit     = WINDOW'(1) << r_rd.widx;
    assign w_self     = WINDOW'(1) << r_idx;
    assign w_alias    = (w_addr == w_a_out);

    always_comb begin
        w_dep_add = '0;
        w_wdata   = r_rd;
        if (i_cmd.port == PORT_OUT) begin
            w_dep_add = (w_eff_wv ? w_wbit : '0) | w_eff_mask;
            w_wdata.tag   = r_epoch;
            w_wdata.wv    = 1'b1;
            w_wdata.widx  = r_idx;
            w_wdata.rmask = '0;
        end else begin
            // input aliasing the output: its old writer is already counted
            w_dep_add = (w_eff_wv && !w_alias) ? w_wbit : '0;
            w_wdata.tag   = r_epoch;
            w_wdata.wv    = w_eff_wv;
            w_wdata.rmask = w_eff_mask | w_self;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            r_mem[r_swp] <= t_entry'(EW'(0));
        end else if (i_cmd.wr_en) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_first <= i_first_in_batch;
            r_nops  <= i_operand_count;
            r_out   <= i_out_array;
            r_in1   <= i_in1_array;
            r_c1    <= i_in1_constant;
            r_in2   <= i_in2_array;
            r_c2    <= i_in2_constant;
        end
        if (i_cmd.take_index) begin
            r_idx  <= r_next[IW-1:0];
            r_deps <= '0;
        end else if (i_cmd.wr_en) begin
            r_deps <= r_deps | w_dep_add;
        end
    end

    logic w_sweep_done;
    assign w_sweep_done = (r_swp == AW'(ARRAY_IDS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_W'(1);
            r_swp   <= '0;
            r_next  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_swp <= w_sweep_done ? '0 : r_swp + AW'(1);
                if (w_sweep_done) r_epoch <= EPOCH_W'(1);
            end
            if (i_cmd.new_batch) begin
                r_next <= '0;
                if (r_epoch != '1) r_epoch <= r_epoch + EPOCH_W'(1);
            end
            if (i_cmd.take_index) begin
                r_next <= r_next + NW'(1);
                r_ovf  <= 1'b0;
            end
            if (i_cmd.overflow) r_ovf <= 1'b1;
        end
    end

    always_comb begin
        w_cnt = '0;
        for (int k = 0; k < WINDOW; k++) begin
            w_cnt = w_cnt + CNT_OUT_W'(r_deps[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_window_overflow <= r_ovf;
            o_instr_index     <= r_ovf ? '0 : IDX_OUT_W'(r_idx);
            o_dep_mask        <= r_ovf ? '0 : MASK_OUT_W'(r_deps);
            o_dep_count       <= r_ovf ? '0 : w_cnt;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.sweep_done = w_sweep_done;
        o_stat.need_sweep = (r_epoch == '1);
        o_stat.first      = r_first;
        o_stat.full       = (r_next >= NW'(WINDOW));
        o_stat.empty      = (r_nops == 2'd0);
        o_stat.live1      = (r_nops >= 2'd2) && !r_c1;
        o_stat.live2      = (r_nops == 2'd3) && !r_c2;
        o_stat.out_busy   = o_valid && !i_ready;
    end

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> (!o_valid || i_ready))
        else $error("result register overwritten before transfer");

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch equals the cleared tag");

    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_window_overflow) |-> (o_dep_mask == '0) && (o_dep_count == '0))
        else $error("overflow result carries dependencies");

endmodule

### sv/instruction_dependency_tracker_unit.sv
// Instruction dependency tracker: per-array last-writer / reader table.
// Per item: capture, start (a table clearing pass on a batch's first item
// once epoch tags run out), window check, then, unless the window is full,
// one read and one write-back of the single-port table per live operand,
// and result load once the last result is taken; one item in work at a time.
// Reset: clears all ARRAY_IDS entries, ready low; rerun every 255 batches.
module instruction_dependency_tracker_unit #(
    parameter int WINDOW    = idt_pkg::DEF_WINDOW,
    parameter int ARRAY_IDS = idt_pkg::DEF_ARRAY_IDS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_first_in_batch,
    input  logic [1:0]                      i_operand_count,
    input  logic [idt_pkg::ID_W-1:0]        i_out_array,
    input  logic [idt_pkg::ID_W-1:0]        i_in1_array,
    input  logic                            i_in1_constant,
    input  logic [idt_pkg::ID_W-1:0]        i_in2_array,
    input  logic                            i_in2_constant,
    // result channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [idt_pkg::IDX_OUT_W-1:0]   o_instr_index,
    output logic [idt_pkg::MASK_OUT_W-1:0]  o_dep_mask,
    output logic [idt_pkg::CNT_OUT_W-1:0]   o_dep_count,
    output logic                            o_window_overflow
);
    import idt_pkg::*;

    // Table entries carry a batch tag; one whose tag differs from the current
    // epoch reads empty, so a new batch needs no clearing pass unless tags run out.
    t_cmd  w_cmd;
    t_stat w_stat;

    idt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // Result register decouples the sides: the next transfer is taken
    // while the previous result still waits.
    idt_dp #(
        .WINDOW    (WINDOW),
        .ARRAY_IDS (ARRAY_IDS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_first_in_batch  (i_first_in_batch),
        .i_operand_count   (i_operand_count),
        .i_out_array       (i_out_array),
        .i_in1_array       (i_in1_array),
        .i_in1_constant    (i_in1_constant),
        .i_in2_array       (i_in2_array),
        .i_in2_constant    (i_in2_constant),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_instr_index     (o_instr_index),
        .o_dep_mask        (o_dep_mask),
        .o_dep_count       (o_dep_count),
        .o_window_overflow (o_window_overflow)
    );

endmodule

### tb/sv/tb_instruction_dependency_tracker_unit.sv
// Testbench for instruction_dependency_tracker_unit: directed and random instruction
// streams, with a behavioral hazard predictor checking every result transfer.
// Depends on idt_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_instruction_dependency_tracker_unit;
    import idt_pkg::*;

    localparam int WIN      = DEF_WINDOW;
    localparam int NIDS     = DEF_ARRAY_IDS;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        logic       first;
        logic [1:0] nops;
        logic [7:0] out_id;
        logic [7:0] in1_id;
        logic       in1_const;
        logic [7:0] in2_id;
        logic       in2_const;
    } instr_t;

    typedef struct packed {
        logic [5:0]  index;
        logic [63:0] deps;
        logic [6:0]  ndeps;
        logic        ovf;
    } hazard_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_first_in_batch = 1'b0;
    logic [1:0] i_operand_count = '0;
    logic [7:0] i_out_array = '0, i_in1_array = '0, i_in2_array = '0;
    logic i_in1_constant = 1'b0, i_in2_constant = 1'b0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [5:0] o_instr_index;
    logic [63:0] o_dep_mask;
    logic [6:0] o_dep_count;
    logic o_window_overflow;

    instruction_dependency_tracker_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state: last writer per array, readers since that write
    logic        wr_valid [NIDS];
    logic [5:0]  wr_index [NIDS];
    logic [63:0] rd_mask  [NIDS];
    int          batch_pos;

    instr_t  pending_instrs[$];
    hazard_t expected_hazards[$];
    int      send_idle_pct, recv_idle_pct;
    int      mismatches;
    int      watchdog;
    bit      timed_out;
    bit      in_taken = 1'b0;

    function automatic void add_instr(instr_t ins);
        pending_instrs.insert(pending_instrs.size(), ins);
    endfunction

    function automatic hazard_t predict_hazards(instr_t ins);
        hazard_t     r;
        logic [7:0]  ids[3];
        logic        live[3];
        logic [63:0] d;
        r = '0;
        d = '0;
        if (ins.first) begin
            for (int a = 0; a < NIDS; a++) begin
                wr_valid[a] = 1'b0;
                wr_index[a] = '0;
                rd_mask[a]  = '0;
            end
            batch_pos = 0;
        end
        if (batch_pos >= WIN) begin
            r.ovf = 1'b1;
            return r;
        end
        r.index = batch_pos[5:0];
        if (ins.nops != 2'd0) begin
            ids[0] = ins.out_id;
            ids[1] = ins.in1_id;
            ids[2] = ins.in2_id;
            live[0] = 1'b1;
            live[1] = ins.nops >= 2'd2 && !ins.in1_const;
            live[2] = ins.nops == 2'd3 && !ins.in2_const;
            for (int j = 0; j < 3; j++)
                if (live[j] && wr_valid[ids[j]]) d[wr_index[ids[j]]] = 1'b1;
            d |= rd_mask[ids[0]];
            rd_mask[ids[0]]  = '0;
            wr_valid[ids[0]] = 1'b1;
            wr_index[ids[0]] = batch_pos[5:0];
            for (int j = 1; j < 3; j++)
                if (live[j]) rd_mask[ids[j]][batch_pos] = 1'b1;
        end
        batch_pos++;
        r.deps  = d;
        r.ndeps = 7'($countones(d));
        return r;
    endfunction

    // driver: next pending instruction goes out at the falling edge
    always @(negedge i_clk) begin
        instr_t taken;
        if (i_rst_n) begin
            if (in_taken) begin
                // transfer took place at the last rising edge
                taken = pending_instrs.pop_front();
                expected_hazards.insert(expected_hazards.size(), predict_hazards(taken));
            end
            if ((!i_valid || in_taken) && pending_instrs.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                i_valid          <= 1'b1;
                i_first_in_batch <= pending_instrs[0].first;
                i_operand_count  <= pending_instrs[0].nops;
                i_out_array      <= pending_instrs[0].out_id;
                i_in1_array      <= pending_instrs[0].in1_id;
                i_in1_constant   <= pending_instrs[0].in1_const;
                i_in2_array      <= pending_instrs[0].in2_id;
                i_in2_constant   <= pending_instrs[0].in2_const;
            end else if (!i_valid || in_taken) begin
                i_valid <= 1'b0;
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: compare each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        hazard_t exp_h;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) watchdog <= 0;
            else watchdog <= watchdog + 1;
            if (o_valid && i_ready) begin
                if (expected_hazards.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: index %0d mask %h",
                                 o_instr_index, o_dep_mask);
                end else begin
                    exp_h = expected_hazards.pop_front();
                    if (o_instr_index !== exp_h.index || o_dep_mask !== exp_h.deps
                            || o_dep_count !== exp_h.ndeps
                            || o_window_overflow !== exp_h.ovf) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp idx %0d mask %h cnt %0d ovf %0b, got idx %0d mask %h cnt %0d ovf %0b",
                                     exp_h.index, exp_h.deps, exp_h.ndeps, exp_h.ovf,
                                     o_instr_index, o_dep_mask, o_dep_count,
                                     o_window_overflow);
                    end
                end
            end
        end
    end

    function automatic instr_t make_instr(logic first, logic [1:0] n, logic [7:0] o,
                                          logic [7:0] a, logic ac, logic [7:0] b,
                                          logic bc);
        make_instr = {first, n, o, a, ac, b, bc};
    endfunction

    // batches over an id pool (small pools make hazards pile up); some items are raw random
    task automatic queue_batch(int len, int pool);
        instr_t      ins;
        logic [31:0] raw;
        for (int k = 0; k < len; k++) begin
            ins.first     = (k == 0);
            ins.nops      = ($urandom_range(9) == 0) ? 2'd0 : 2'($urandom_range(3, 1));
            ins.out_id    = 8'($urandom_range(pool - 1));
            ins.in1_id    = 8'($urandom_range(pool - 1));
            ins.in2_id    = 8'($urandom_range(pool - 1));
            ins.in1_const = ($urandom_range(5) == 0);
            ins.in2_const = ($urandom_range(5) == 0);
            if ($urandom_range(15) == 0) begin
                raw = $urandom;
                ins = raw[$bits(instr_t)-1:0];
                ins.first = (k == 0) | ins.first;
            end
            add_instr(ins);
        end
    endtask

    task automatic drain();
        while (pending_instrs.size() > 0 || expected_hazards.size() > 0 || i_valid) begin
            @(posedge i_clk);
            if (watchdog >= WDOG_MAX) begin
                timed_out = 1'b1;
                return;
            end
        end
    endtask

    initial begin
        int sent;
        mismatches = 0;
        watchdog = 0;
        timed_out = 1'b0;
        batch_pos = 0;
        for (int a = 0; a < NIDS; a++) begin
            wr_valid[a] = 1'b0;
            wr_index[a] = '0;
            rd_mask[a]  = '0;
        end
        send_idle_pct = 9;
        recv_idle_pct = 78;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: extremes, all operand counts, constants, self-read, empty
        add_instr(make_instr(1'b1, 2'd3, 8'd255, 8'd0, 1'b0, 8'd255, 1'b0));
        add_instr(make_instr(1'b0, 2'd1, 8'd0, 8'd255, 1'b1, 8'd255, 1'b1));
        add_instr(make_instr(1'b0, 2'd2, 8'd7, 8'd255, 1'b0, 8'd0, 1'b0));
        add_instr(make_instr(1'b0, 2'd3, 8'd7, 8'd7, 1'b0, 8'd0, 1'b1));
        add_instr(make_instr(1'b0, 2'd0, 8'd7, 8'd255, 1'b0, 8'd0, 1'b0));
        add_instr(make_instr(1'b0, 2'd3, 8'd255, 8'd7, 1'b1, 8'd7, 1'b0));
        add_instr(make_instr(1'b0, 2'd2, 8'd0, 8'd7, 1'b1, 8'd170, 1'b0));
        add_instr(make_instr(1'b0, 2'd3, 8'd85, 8'd170, 1'b0, 8'd85, 1'b0));
        add_instr(make_instr(1'b1, 2'd3, 8'd7, 8'd0, 1'b0, 8'd255, 1'b0));
        // window overflow: fill a batch past WIN, then restart
        for (int k = 0; k < WIN + 3; k++)
            add_instr(make_instr(k == 0, 2'd3, 8'(k % 3), 8'((k + 1) % 3), 1'b0,
                                 8'd200, 1'b0));
        add_instr(make_instr(1'b1, 2'd3, 8'd1, 8'd1, 1'b0, 8'd1, 1'b0));

        // random: three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            sent = 0;
            while (sent < 440) begin
                int len;
                len = ($urandom_range(19) == 0) ? $urandom_range(WIN + 4, WIN)
                                               : $urandom_range(24, 1);
                queue_batch(len, ($urandom_range(3) == 0) ? 256 : $urandom_range(12, 2));
                sent += len;
            end
            drain();
            if (timed_out) break;
            if (ph == 0) begin
                send_idle_pct = 78;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        if (!timed_out) repeat (20) @(posedge i_clk);

        if (timed_out) begin
            $display("instruction_dependency_tracker_unit test failed");
        end else if (mismatches == 0 && expected_hazards.size() == 0) begin
            $display("instruction_dependency_tracker_unit test passed");
        end else begin
            $display("instruction_dependency_tracker_unit test failed");
        end
        $finish;
    end

endmodule
